// ===== hdl/rrd_pkg.sv =====
// Package: shared constants, types and register codes of the reverse ring delay.
`default_nettype none

package rrd_pkg;

  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned MIN_LEN     = 2;
  localparam int unsigned RESET_LEN   = (STORE_DEPTH < 16384) ? STORE_DEPTH : 16384;
  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DELAY_LENGTH = 2'd0,
    REG_REVERSE_MODE = 2'd1
  } cfg_reg_e;

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata;
    logic    re;
    addr_t   raddr;
  } mem_req_t;

  typedef struct packed {
    logic    valid;
    logic    bypass;
    sample_t data;
  } issue_t;

endpackage

`default_nettype wire

// ===== hdl/rrd_in_if.sv =====
// Interface: input sample channel.
`default_nettype none

interface rrd_in_if;
  import rrd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrd_out_if.sv =====
// Interface: output sample channel.
`default_nettype none

interface rrd_out_if;
  import rrd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrd_cfg_if.sv =====
// Interface: configuration register write channel.
`default_nettype none

interface rrd_cfg_if;
  import rrd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module rrd_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rrd_ptr_ctrl.sv =====
// Pointer control: ring pointers, phase, config registers and store clearing sweep.
`default_nettype none

module rrd_ptr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rrd_in_if.sink                 in_i,
  rrd_cfg_if.sink                cfg_i,
  input  wire logic              room_i,
  output rrd_pkg::mem_req_t      mem_req_o,
  output rrd_pkg::issue_t        issue_o
);
  import rrd_pkg::*;

  addr_t wp_q, wp_d;
  addr_t rp_q, rp_d;
  logic  phase_q, phase_d;
  len_t  len_q, len_d;
  logic  rev_q, rev_d;
  logic  clr_busy_q, clr_busy_d;
  addr_t clr_addr_q, clr_addr_d;

  logic  in_fire, cfg_fire;
  len_t  wp_ext, rp_ext, wp_inc, rp_inc, rp_dec, len_m1;
  addr_t wp_step, rp_fwd, rp_bwd, rp_align;

  function automatic len_t clamp_len(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < MIN_LEN) begin
      return len_t'(MIN_LEN);
    end
    if (w > STORE_DEPTH) begin
      return len_t'(STORE_DEPTH);
    end
    return len_t'(w);
  endfunction

  assign in_i.ready  = !clr_busy_q && room_i;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    wp_ext   = len_t'(wp_q);
    rp_ext   = len_t'(rp_q);
    len_m1   = len_q - len_t'(1);
    wp_inc   = wp_ext + len_t'(1);
    rp_inc   = rp_ext + len_t'(1);
    rp_dec   = rp_ext - len_t'(1);
    wp_step  = (wp_inc >= len_q) ? '0 : addr_t'(wp_inc);
    rp_fwd   = (rp_inc >= len_q) ? '0 : addr_t'(rp_inc);
    rp_bwd   = (rp_q == '0 || rp_dec >= len_q) ? addr_t'(len_m1) : addr_t'(rp_dec);
    rp_align = (wp_q == '0) ? addr_t'(len_m1) : addr_t'(wp_ext - len_t'(1));
  end

  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    phase_d    = phase_q;
    len_d      = len_q;
    rev_d      = rev_q;
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + addr_t'(1);
      if (clr_addr_q == addr_t'(STORE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg_i.addr))
        REG_DELAY_LENGTH: len_d = clamp_len(cfg_i.data);
        REG_REVERSE_MODE: begin
          rev_d = cfg_i.data[0];
          rp_d  = rp_align;
        end
        default: ;
      endcase
    end
    if (in_fire) begin
      phase_d = !phase_q;
      if (phase_q) begin
        wp_d = wp_step;
        rp_d = rev_q ? rp_bwd : rp_fwd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      phase_q    <= 1'b0;
      len_q      <= len_t'(RESET_LEN);
      rev_q      <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      phase_q    <= phase_d;
      len_q      <= len_d;
      rev_q      <= rev_d;
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    mem_req_o.we    = clr_busy_q || (in_fire && phase_q);
    mem_req_o.waddr = clr_busy_q ? clr_addr_q : wp_q;
    mem_req_o.wdata = clr_busy_q ? '0 : in_i.sample_in;
    mem_req_o.re    = in_fire;
    mem_req_o.raddr = rp_q;
    issue_o.valid   = in_fire;
    issue_o.bypass  = phase_q && (rp_q == wp_q);
    issue_o.data    = in_i.sample_in;
  end

endmodule

`default_nettype wire

// ===== hdl/rrd_out_queue.sv =====
// Output side: read return stage, write-through bypass and a small result queue.
`default_nettype none

module rrd_out_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  rrd_pkg::issue_t        issue_i,
  input  rrd_pkg::sample_t       rdata_i,
  output logic                   room_o,
  rrd_out_if.source              out_o
);
  import rrd_pkg::*;

  logic                v1_q;
  logic                byp1_q;
  sample_t             bd1_q;
  sample_t             q_data_q [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                push, pop;
  sample_t             push_data;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign push      = v1_q;
  assign pop       = out_o.valid && out_o.ready;
  assign push_data = byp1_q ? bd1_q : rdata_i;

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.sample_out = q_data_q[head_q];
  assign room_o           = (32'(cnt_q) + 32'(v1_q)) < QUEUE_DEPTH;

  always_comb begin
    head_d = pop  ? next_ptr(head_q) : head_q;
    tail_d = push ? next_ptr(tail_q) : tail_q;
    cnt_d  = QCNT_W'(32'(cnt_q) + 32'(push) - 32'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      v1_q   <= issue_i.valid;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      byp1_q <= issue_i.bypass;
      bd1_q  <= issue_i.data;
    end
    if (push) begin
      q_data_q[tail_q] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/reverse_ring_delay.sv =====
// Reverse ring delay: 16-bit sample ring with forward or backward readout.
//
// Channels: in_ch_i takes one signed 16-bit sample per transfer; out_ch_o
// returns exactly one signed 16-bit sample per input, in order. cfg_i writes
// register 0 (delay_length, clamped to 2..STORE_DEPTH) or register 1
// (reverse_mode, bit 0; any write realigns the read pointer one entry
// behind the write pointer). Other indexes are ignored. cfg_i is always ready.
// Items alternate idle/active phase, starting idle; active items write the ring.
// A result goes through the registered RAM read and then the result queue.
// Throughput: one item per cycle while in_ch_i is ready; the store is a simple
// dual-port RAM, so an item's write and read both go in the accept cycle.
// Reset: pointers and phase clear, registers take their reset values, then a
// clearing sweep writes zero to all STORE_DEPTH entries, with in_ch_i not
// ready meanwhile.
// Stall: a three-entry result queue absorbs results in flight; in_ch_i drops
// ready once accepted-but-undelivered items fill it and resumes as it drains.
`default_nettype none

module reverse_ring_delay (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrd_in_if.sink    in_ch_i,
  rrd_out_if.source out_ch_o,
  rrd_cfg_if.sink   cfg_i
);
  import rrd_pkg::*;

  mem_req_t              mem_req;
  issue_t                issue;
  logic                  room;
  logic [SAMPLE_W-1:0]   rdata_raw;
  sample_t               rdata;

  rrd_ptr_ctrl u_ptr_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch_i),
    .cfg_i     (cfg_i),
    .room_i    (room),
    .mem_req_o (mem_req),
    .issue_o   (issue)
  );

  rrd_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = sample_t'(rdata_raw);

  rrd_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .rdata_i (rdata),
    .room_o  (room),
    .out_o   (out_ch_o)
  );

endmodule

`default_nettype wire

// ===== hdl/rrd_checker.sv =====
// Port-level checker for the reverse ring delay, bound to the top level.
`default_nettype none

module rrd_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [15:0]           sample_out_i
);
  import rrd_pkg::*;

  logic [QCNT_W-1:0] pending_q, pending_d;
  logic              in_fire, out_fire;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_fire  = out_valid_i && out_ready_i;
  assign pending_d = QCNT_W'(32'(pending_q) + 32'(in_fire) - 32'(out_fire));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_out_i))
    else $error("output changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> pending_q != '0)
    else $error("result delivered without a pending input");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pending_q < QCNT_W'(QUEUE_DEPTH))
    else $error("input ready with result queue full");

endmodule

bind reverse_ring_delay rrd_checker u_rrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch_i.valid),
  .in_ready_i   (in_ch_i.ready),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .sample_out_i (out_ch_o.sample_out)
);

`default_nettype wire

// ===== sim/reverse_ring_delay_tb.sv =====
// Testbench: reverse ring delay, directed and random samples checked against a ring predictor.
`timescale 1ns / 100ps

module reverse_ring_delay_tb;
  import rrd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int DRAIN_LIMIT = 5000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  class ring_scoreboard;
    bit signed [SAMPLE_W-1:0] ring[STORE_DEPTH];
    int unsigned              wr_ptr;
    int unsigned              rd_ptr;
    bit                       write_phase;
    bit [CFG_DATA_W-1:0]      len_reg = CFG_DATA_W'(RESET_LEN);
    bit                       reverse;
    sample_t                  expected_q[$];
    int                       errors;

    function int unsigned ring_len();
      int unsigned n;
      n = len_reg;
      if (n < MIN_LEN) n = MIN_LEN;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY_LENGTH: len_reg = data;
        REG_REVERSE_MODE: begin
          reverse = data[0];
          rd_ptr = (wr_ptr == 0) ? ring_len() - 1 : wr_ptr - 1;
        end
        default: ;
      endcase
    endfunction

    // One result per input; only the write phase stores and moves the pointers.
    function void note_input(sample_t s);
      int unsigned n;
      sample_t     rd_val;
      n = ring_len();
      if (write_phase) begin
        ring[wr_ptr % STORE_DEPTH] = s;
        wr_ptr = (wr_ptr + 1 >= n) ? 0 : wr_ptr + 1;
        rd_val = ring[rd_ptr % STORE_DEPTH];
        if (!reverse)
          rd_ptr = (rd_ptr + 1 >= n) ? 0 : rd_ptr + 1;
        else if (rd_ptr == 0 || rd_ptr - 1 >= n)
          rd_ptr = n - 1;
        else
          rd_ptr = rd_ptr - 1;
      end else begin
        rd_val = ring[rd_ptr % STORE_DEPTH];
      end
      write_phase = ~write_phase;
      expected_q.push_back(rd_val);
    endfunction

    function void check_result(sample_t got);
      sample_t exp_val;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected sample_out %0d", $time, got);
        return;
      end
      exp_val = expected_q.pop_front();
      if (got !== exp_val) begin
        errors++;
        if (errors <= 10)
          $display("%0t: sample_out mismatch: expected %0d, got %0d", $time, exp_val, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_pct = 0;
  int   recv_pct = 0;

  ring_scoreboard sb = new();

  rrd_in_if  in_if ();
  rrd_out_if out_if ();
  rrd_cfg_if cfg_if ();

  reverse_ring_delay u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_if),
    .out_ch_o (out_if),
    .cfg_i    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_pct);
    if (out_if.valid && out_if.ready) sb.check_result(out_if.sample_out);
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 57; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 57; end
      IDLE_BOTH: begin send_pct = 12; recv_pct = 12; end
      default:   begin send_pct = 0;  recv_pct = 0;  end
    endcase
  endtask

  // valid stays high between back-to-back transfers; it drops for a gap or when settle() drains
  task automatic send_sample(sample_t s);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(s);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic sample_t pick_sample();
    sample_t corner[6] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh5555, 16'shaaaa};
    logic [31:0] r;
    if ($urandom_range(9) == 0) return corner[$urandom_range(5)];
    r = $urandom();
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    logic [CFG_DATA_W-1:0] corner[6] = '{15'd0, 15'd1, 15'd2, 15'd16384, 15'd16385, 15'd32767};
    case ($urandom_range(9))
      0:       return corner[$urandom_range(5)];
      1:       return CFG_DATA_W'($urandom_range(32767));
      default: return CFG_DATA_W'($urandom_range(48, 2));
    endcase
  endfunction

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sample_t corner_run[10] = '{16'sd0, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1, 16'sh5555,
                                16'shaaaa, 16'sd100, -16'sd100, 16'sd7};
    logic [CFG_DATA_W-1:0] len_val;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.addr     = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, pointers advance past the short ring used next
    set_idle(IDLE_NONE);
    foreach (corner_run[i]) send_sample(corner_run[i]);

    // pointers beyond a shortened ring, reverse readout
    settle();
    write_reg(REG_REVERSE_MODE, 15'h7fff);
    write_reg(REG_DELAY_LENGTH, 15'd3);
    cfg_if.valid <= 1'b0;
    for (int i = 0; i < 4; i++) send_sample(pick_sample());

    // spare indexes ignored, length below minimum
    settle();
    write_reg(REG_SPARE_LO, 15'h7fff);
    write_reg(REG_SPARE_HI, 15'd1);
    write_reg(REG_DELAY_LENGTH, 15'd0);
    cfg_if.valid <= 1'b0;
    for (int i = 0; i < 4; i++) send_sample(pick_sample());

    // length above the store depth
    settle();
    write_reg(REG_DELAY_LENGTH, 15'h7fff);
    write_reg(REG_REVERSE_MODE, 15'd0);
    cfg_if.valid <= 1'b0;
    for (int i = 0; i < 4; i++) send_sample(pick_sample());

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      set_idle(idle_mode_e'(p % 4));
      if (p == 0) len_val = CFG_DATA_W'(MIN_LEN);
      else if (p == 1) len_val = CFG_DATA_W'(STORE_DEPTH);
      else len_val = pick_length();
      write_reg(REG_DELAY_LENGTH, len_val);
      if (p < 2 || $urandom_range(4) != 0)
        write_reg(REG_REVERSE_MODE, CFG_DATA_W'($urandom_range(32767)));
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_W'($urandom_range(32767)));
      cfg_if.valid <= 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
    end

    settle();
    repeat (5) @(posedge clk_i);
    sb.errors += sb.pending();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rrd_pkg.sv
hdl/rrd_in_if.sv
hdl/rrd_out_if.sv
hdl/rrd_cfg_if.sv
hdl/rrd_ram.sv
hdl/rrd_ptr_ctrl.sv
hdl/rrd_out_queue.sv
hdl/reverse_ring_delay.sv
hdl/rrd_checker.sv
sim/reverse_ring_delay_tb.sv
